// ----- hw/rtl/cht_pkg.sv -----
// Package with shared types, constants and codes of the chained hash table.
`timescale 1ns / 1ps
package cht_pkg;
  localparam int MaxBuckets = 64;
  localparam int PoolNodes  = 256;
  localparam int BucketCountReset = 11;

  localparam logic [1:0] ACT_FIND   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic ADDR_BUCKET_COUNT = 1'b0;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_HEAD, S_READ, S_CHECK, S_WRITE, S_FIX, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word
    logic init_step; // one step of the clearing pass
    logic mod_step;  // one step of the modulo unit
    logic head_rd;   // read bucket head and tail
    logic node_rd;   // read current node
    logic advance;   // move to the next node of the chain
    logic do_insert;
    logic do_remove;
    logic fix_tail;
    logic set_status;
    logic [1:0] status;
    logic set_found;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_done;
    logic mod_done;
    logic cur_nil;
    logic key_hit;
    logic free_nil;
    logic walk_limit;
  } stat_t;
endpackage

// ----- hw/rtl/cht_if.sv -----
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] key;
  logic [31:0] thread_id;
  logic [31:0] process_id;
  logic [63:0] image_low;
  logic [63:0] image_high;
  modport source (output valid, action, key, thread_id, process_id, image_low, image_high,
                  input ready);
  modport sink (input valid, action, key, thread_id, process_id, image_low, image_high,
                output ready);
endinterface

interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_thread;
  logic [31:0] found_process;
  logic [63:0] found_image_low;
  logic [63:0] found_image_high;
  modport source (output valid, status, found_thread, found_process, found_image_low,
                  found_image_high, input ready);
  modport sink (input valid, status, found_thread, found_process, found_image_low,
                found_image_high, output ready);
endinterface

// ----- hw/rtl/cht_ctrl.sv -----
// Controller state machine that sequences each table operation.
`timescale 1ns / 1ps
module cht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     action,
  output logic           out_valid,
  input  logic           out_ready,
  input  cht_pkg::stat_t stat,
  output cht_pkg::cmd_t  cmd
);
  cht_pkg::state_t state, state_next;
  logic [1:0] act, act_next;

  // State and held action.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cht_pkg::S_INIT;
      act <= cht_pkg::ACT_FIND;
    end else begin
      state <= state_next;
      act <= act_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    act_next = act;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      cht_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_done) state_next = cht_pkg::S_IDLE;
      end
      cht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          act_next = action;
          state_next = cht_pkg::S_MOD;
        end
      end
      cht_pkg::S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) state_next = cht_pkg::S_HEAD;
      end
      cht_pkg::S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_next = cht_pkg::S_READ;
      end
      cht_pkg::S_READ: begin
        if (stat.cur_nil || stat.walk_limit) begin
          // End of chain: key absent.
          cmd.set_status = 1'b1;
          if (act == cht_pkg::ACT_INSERT) begin
            if (stat.free_nil) begin
              cmd.status = cht_pkg::ST_FULL;
              state_next = cht_pkg::S_DONE;
            end else begin
              cmd.status = cht_pkg::ST_OK;
              state_next = cht_pkg::S_WRITE;
            end
          end else begin
            cmd.status = cht_pkg::ST_MISSING;
            state_next = cht_pkg::S_DONE;
          end
        end else begin
          cmd.node_rd = 1'b1;
          state_next = cht_pkg::S_CHECK;
        end
      end
      cht_pkg::S_CHECK: begin
        if (stat.key_hit) begin
          cmd.set_status = 1'b1;
          case (act)
            cht_pkg::ACT_FIND: begin
              cmd.status = cht_pkg::ST_OK;
              cmd.set_found = 1'b1;
              state_next = cht_pkg::S_DONE;
            end
            cht_pkg::ACT_INSERT: begin
              cmd.status = cht_pkg::ST_PRESENT;
              state_next = cht_pkg::S_DONE;
            end
            cht_pkg::ACT_REMOVE: begin
              cmd.status = cht_pkg::ST_OK;
              state_next = cht_pkg::S_WRITE;
            end
            default: begin
              cmd.status = cht_pkg::ST_MISSING;
              state_next = cht_pkg::S_DONE;
            end
          endcase
        end else begin
          cmd.advance = 1'b1;
          state_next = cht_pkg::S_READ;
        end
      end
      cht_pkg::S_WRITE: begin
        if (act == cht_pkg::ACT_INSERT) cmd.do_insert = 1'b1;
        else cmd.do_remove = 1'b1;
        state_next = cht_pkg::S_FIX;
      end
      cht_pkg::S_FIX: begin
        cmd.fix_tail = 1'b1;
        state_next = cht_pkg::S_DONE;
      end
      cht_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = cht_pkg::S_IDLE;
      end
      default: state_next = cht_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/cht_datapath.sv -----
// Datapath: modulo unit, bucket tables, node memories, free list and result word.
`timescale 1ns / 1ps
module cht_datapath #(
  parameter int MAX_BUCKETS = cht_pkg::MaxBuckets,
  parameter int POOL_NODES  = cht_pkg::PoolNodes
) (
  input  logic           clk,
  input  logic           rst,
  input  cht_pkg::cmd_t  cmd,
  output cht_pkg::stat_t stat,
  input  logic [6:0]     bucket_count,
  input  logic [31:0]    key,
  input  logic [31:0]    thread_id,
  input  logic [31:0]    process_id,
  input  logic [63:0]    image_low,
  input  logic [63:0]    image_high,
  output logic [1:0]     status,
  output logic [31:0]    found_thread,
  output logic [31:0]    found_process,
  output logic [63:0]    found_image_low,
  output logic [63:0]    found_image_high
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int IW = $clog2(POOL_NODES);
  localparam int CW = $clog2(MAX_BUCKETS + 1);
  localparam int INIT_LEN = (POOL_NODES > MAX_BUCKETS) ? POOL_NODES : MAX_BUCKETS;
  localparam int KW = $clog2(INIT_LEN + 1);
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  // Memories.
  logic [NW-1:0] bucket_head [MAX_BUCKETS];
  logic [NW-1:0] chain_tail  [MAX_BUCKETS];
  logic [31:0]   node_key     [POOL_NODES];
  logic [31:0]   node_thread  [POOL_NODES];
  logic [31:0]   node_process [POOL_NODES];
  logic [63:0]   node_name_lo [POOL_NODES];
  logic [63:0]   node_name_hi [POOL_NODES];
  logic [NW-1:0] node_link    [POOL_NODES];

  // Held request.
  logic [31:0] r_key, r_thread, r_process;
  logic [63:0] r_img_lo, r_img_hi;
  logic [NW-1:0] free_head;
  logic [KW-1:0] init_cnt;

  // Modulo unit: restoring, one quotient bit per cycle.
  logic [CW-1:0] divisor;
  logic [CW-1:0] rem;
  logic [31:0]   dividend;
  logic [5:0]    mod_cnt;
  logic [CW:0]   trial;
  logic [BW-1:0] bucket;

  // Walk state.
  logic [NW-1:0] cur, prev, cur_link;
  logic [31:0]   cur_key;
  logic [NW-1:0] tail_b;
  logic [NW-1:0] head_b;
  logic [NW:0]   steps;

  always_comb begin
    if (bucket_count == 7'd0) divisor = CW'(1);
    else if ({25'd0, bucket_count} > 32'(MAX_BUCKETS)) divisor = CW'(MAX_BUCKETS);
    else divisor = CW'(bucket_count);
    trial = {rem, dividend[31]} - {1'b0, divisor};
  end
  assign bucket = BW'(rem);

  // The clearing pass ends in the cycle that handles its last entry.
  assign stat.init_done  = (init_cnt == KW'(INIT_LEN - 1));
  assign stat.mod_done   = (mod_cnt == 6'd32);
  assign stat.cur_nil    = (cur == NIL);
  assign stat.key_hit    = (cur_key == r_key);
  assign stat.free_nil   = (free_head == NIL);
  assign stat.walk_limit = (steps >= (NW+1)'(POOL_NODES));

  // Control registers: clearing pass, free head, modulo progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
      free_head <= '0;
      mod_cnt <= '0;
    end else begin
      if (cmd.init_step) init_cnt <= init_cnt + 1'b1;
      if (cmd.load) mod_cnt <= '0;
      else if (cmd.mod_step && mod_cnt != 6'd32) mod_cnt <= mod_cnt + 6'd1;
      if (cmd.do_insert) free_head <= cur_link;
      if (cmd.do_remove) free_head <= cur;
    end
  end

  // Request capture, modulo and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_key <= key;
      r_thread <= thread_id;
      r_process <= process_id;
      r_img_lo <= image_low;
      r_img_hi <= {8'd0, image_high[55:0]};
      dividend <= key;
      rem <= '0;
    end else if (cmd.mod_step && mod_cnt != 6'd32) begin
      dividend <= {dividend[30:0], 1'b0};
      if (!trial[CW]) rem <= trial[CW-1:0];
      else rem <= {rem[CW-2:0], dividend[31]};
    end
    if (cmd.head_rd) begin
      cur <= bucket_head[bucket];
      head_b <= bucket_head[bucket];
      tail_b <= chain_tail[bucket];
      prev <= NIL;
      steps <= '0;
    end else if (cmd.advance) begin
      prev <= cur;
      cur <= cur_link;
      steps <= steps + 1'b1;
    end else if (cmd.set_status && cur == NIL) begin
      // Absent key: load the free head and read its link for an insert.
      cur <= free_head;
      cur_link <= node_link[free_head[IW-1:0]];
    end
    if (cmd.node_rd) begin
      cur_key <= node_key[cur[IW-1:0]];
      cur_link <= node_link[cur[IW-1:0]];
    end
  end

  // Table and memory updates.
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      if (init_cnt < KW'(POOL_NODES)) node_link[init_cnt[IW-1:0]] <= NW'(init_cnt + 1'b1);
      if (init_cnt < KW'(MAX_BUCKETS)) begin
        bucket_head[init_cnt[BW-1:0]] <= NIL;
        chain_tail[init_cnt[BW-1:0]] <= NIL;
      end
    end
    if (cmd.do_insert) begin
      node_key[cur[IW-1:0]] <= r_key;
      node_thread[cur[IW-1:0]] <= r_thread;
      node_process[cur[IW-1:0]] <= r_process;
      node_name_lo[cur[IW-1:0]] <= r_img_lo;
      node_name_hi[cur[IW-1:0]] <= r_img_hi;
      node_link[cur[IW-1:0]] <= NIL;
      chain_tail[bucket] <= cur;
      if (tail_b == NIL || head_b == NIL) bucket_head[bucket] <= cur;
    end
    if (cmd.do_remove) begin
      node_link[cur[IW-1:0]] <= free_head;
      if (prev == NIL) bucket_head[bucket] <= cur_link;
      if (tail_b == cur) chain_tail[bucket] <= prev;
    end
    if (cmd.fix_tail) begin
      // Second link write: append after old tail, or bypass on remove.
      if (cur_key == r_key && prev != NIL && tail_b != cur) begin
        node_link[prev[IW-1:0]] <= cur_link;
      end else if (cur_key == r_key && prev != NIL) begin
        node_link[prev[IW-1:0]] <= cur_link;
      end else if (cur_key != r_key && tail_b != NIL && head_b != NIL && tail_b != cur) begin
        node_link[tail_b[IW-1:0]] <= cur;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status <= cht_pkg::ST_MISSING;
      found_thread <= '0;
      found_process <= '0;
      found_image_low <= '0;
      found_image_high <= '0;
    end
    if (cmd.set_status) status <= cmd.status;
    if (cmd.set_found) begin
      found_thread <= node_thread[cur[IW-1:0]];
      found_process <= node_process[cur[IW-1:0]];
      found_image_low <= node_name_lo[cur[IW-1:0]];
      found_image_high <= node_name_hi[cur[IW-1:0]];
    end
  end
endmodule

// ----- hw/rtl/chained_hash_table_unit.sv -----
// Top level of the chained hash table: config registers, controller and datapath.
//
//   channel | direction | fields
//   req     | in        | action, key, thread_id, process_id, image_low, image_high
//   rsp     | out       | status, found_thread, found_process, found_image_low/high
//   apb     | in        | bucket_count at address 0
//
// A word passes the modulo unit, the bucket head read and the walk over its
// chain, with a read and a check for each node passed over; an insert or
// remove that changes the table adds the write and tail fix states. After reset
// a clearing pass over the larger of POOL_NODES and MAX_BUCKETS entries runs
// before the first request word is taken. One word is in flight at a time;
// a stalled response holds the block until it is taken.
`timescale 1ns / 1ps
module chained_hash_table_unit #(
  parameter int MAX_BUCKETS = cht_pkg::MaxBuckets,
  parameter int POOL_NODES  = cht_pkg::PoolNodes
) (
  input  logic        clk,
  input  logic        rst,
  cht_req_if.sink     req,
  cht_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [6:0] bucket_count;
  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t stat;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= 7'(cht_pkg::BucketCountReset);
    else if (psel && penable && pwrite && paddr == cht_pkg::ADDR_BUCKET_COUNT)
      bucket_count <= pwdata[6:0];
  end
  assign prdata = (paddr == cht_pkg::ADDR_BUCKET_COUNT) ? {25'd0, bucket_count} : 32'd0;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .action(req.action), .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  cht_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .bucket_count(bucket_count),
    .key(req.key), .thread_id(req.thread_id), .process_id(req.process_id),
    .image_low(req.image_low), .image_high(req.image_high),
    .status(rsp.status), .found_thread(rsp.found_thread),
    .found_process(rsp.found_process), .found_image_low(rsp.found_image_low),
    .found_image_high(rsp.found_image_high)
  );
endmodule
